// ----- src/lsee_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package lsee_pkg;

   // Frame geometry and sample format
   localparam int FRAME_PIXELS = 128;
   localparam int SAMPLE_BITS  = 12;
   localparam int CHANNELS     = 2;

   localparam int PIX_W  = $clog2(FRAME_PIXELS);
   localparam int ADDR_W = $clog2(CHANNELS * FRAME_PIXELS);

   // Register and result field widths
   localparam int CFG_W     = 7;
   localparam int NB_W      = 8;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_LAST   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HIGH = 2'd3;

   // Register reset values
   localparam logic [CFG_W-1:0] SCAN_FIRST_RST  = 7'd9;
   localparam logic [CFG_W-1:0] SCAN_LAST_RST   = 7'd119;
   localparam logic [CFG_W-1:0] WINDOW_LOW_RST  = 7'd31;
   localparam logic [CFG_W-1:0] WINDOW_HIGH_RST = 7'd95;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // take a sample item into the frame store
      logic init;   // restart the scan address and level tracking
      logic clear;  // clear the frame counts before the counting pass
      logic issue;  // read the next scan pixel
      logic pass2;  // pixels now feed the boundary reporting pass
      logic flush;  // send any half-filled or empty final item
   } lsee_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic frame_end;  // offered sample completes its channel's frame
      logic empty;      // scan range holds no pixel
      logic pos_at_hi;  // scan address sits on the last scan pixel
      logic rd_last;    // last scan pixel is being evaluated
   } lsee_status_type;

endpackage

`default_nettype wire

// ----- src/line_scan_edge_extractor.sv -----
// Top level of the two-channel line-scan edge extractor.
// Samples load at one item per cycle while busy is low; an item that does not finish a
// frame produces no result. The item that finishes a frame raises busy for two passes
// over the frame store read port, one pixel per cycle, or for neither pass when the scan
// range (scan_first to scan_last clipped) is empty. Result items are registered and strobe
// out in the cycle after the pixel that completes them is evaluated, the last no later than
// the cycle in which busy falls; results cannot be held off. Synchronous reset clears the
// per-channel pixel counters and running peaks and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module line_scan_edge_extractor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_channel,
   input  logic [lsee_pkg::SAMPLE_BITS-1:0]  req_sample,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsee_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsee_pkg::CFG_W-1:0]        csr_data,
   output logic                              rsp_valid,
   output logic                              rsp_out_channel,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_boundary_a,
   output logic                              rsp_boundary_a_valid,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_boundary_b,
   output logic                              rsp_boundary_b_valid,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_white_count,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_change_count,
   output logic [lsee_pkg::NB_W-1:0]         rsp_boundary_count,
   output logic [lsee_pkg::SAMPLE_BITS-1:0]  rsp_peak,
   output logic                              rsp_last
);
   import lsee_pkg::*;

   lsee_cmd_type    cmd;
   lsee_status_type status;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   lsee_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   lsee_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_channel          (req_channel),
      .req_sample           (req_sample),
      .csr_wr               (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_valid            (rsp_valid),
      .rsp_out_channel      (rsp_out_channel),
      .rsp_boundary_a       (rsp_boundary_a),
      .rsp_boundary_a_valid (rsp_boundary_a_valid),
      .rsp_boundary_b       (rsp_boundary_b),
      .rsp_boundary_b_valid (rsp_boundary_b_valid),
      .rsp_white_count      (rsp_white_count),
      .rsp_change_count     (rsp_change_count),
      .rsp_boundary_count   (rsp_boundary_count),
      .rsp_peak             (rsp_peak),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

// ----- src/lsee_ctrl.sv -----
// Frame scan sequencer: load, counting pass, reporting pass, final item.
`timescale 1ns / 1ps
`default_nettype none

module lsee_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output lsee_pkg::lsee_cmd_type    cmd,
   input  lsee_pkg::lsee_status_type status
);
   import lsee_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT1 = 3'd1;
   localparam logic [2:0] S_RUN1  = 3'd2;
   localparam logic [2:0] S_INIT2 = 3'd3;
   localparam logic [2:0] S_RUN2  = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       issue_done_ff, issue_done_in;

   assign busy = (state_ff != S_IDLE);

   // Sequence the two passes over the finished frame
   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      issue_done_in = issue_done_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            if (start && status.frame_end) begin
               state_in = S_INIT1;
            end
         end
         S_INIT1: begin
            cmd.init      = 1'b1;
            cmd.clear     = 1'b1;
            issue_done_in = 1'b0;
            state_in      = status.empty ? S_FLUSH : S_RUN1;
         end
         S_RUN1: begin
            cmd.issue = ~issue_done_ff;
            if (cmd.issue && status.pos_at_hi) begin
               issue_done_in = 1'b1;
            end
            if (status.rd_last) begin
               state_in = S_INIT2;
            end
         end
         S_INIT2: begin
            cmd.init      = 1'b1;
            issue_done_in = 1'b0;
            state_in      = S_RUN2;
         end
         S_RUN2: begin
            cmd.pass2 = 1'b1;
            cmd.issue = ~issue_done_ff;
            if (cmd.issue && status.pos_at_hi) begin
               issue_done_in = 1'b1;
            end
            if (status.rd_last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/lsee_datapath.sv -----
// Frame store, peak tracking, threshold compare, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module lsee_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lsee_pkg::lsee_cmd_type            cmd,
   output lsee_pkg::lsee_status_type         status,
   input  logic                              req_channel,
   input  logic [lsee_pkg::SAMPLE_BITS-1:0]  req_sample,
   input  logic                              csr_wr,
   input  logic [lsee_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsee_pkg::CFG_W-1:0]        csr_data,
   output logic                              rsp_valid,
   output logic                              rsp_out_channel,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_boundary_a,
   output logic                              rsp_boundary_a_valid,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_boundary_b,
   output logic                              rsp_boundary_b_valid,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_white_count,
   output logic [lsee_pkg::CFG_W-1:0]        rsp_change_count,
   output logic [lsee_pkg::NB_W-1:0]         rsp_boundary_count,
   output logic [lsee_pkg::SAMPLE_BITS-1:0]  rsp_peak,
   output logic                              rsp_last
);
   import lsee_pkg::*;

   localparam logic [CFG_W-1:0] LAST_PIX = CFG_W'(FRAME_PIXELS - 1);

   // Configuration registers
   logic [CFG_W-1:0] scan_first_ff, scan_first_in;
   logic [CFG_W-1:0] scan_last_ff, scan_last_in;
   logic [CFG_W-1:0] window_low_ff, window_low_in;
   logic [CFG_W-1:0] window_high_ff, window_high_in;

   // Per-channel load state
   logic [PIX_W-1:0]       pix_cnt_ff [CHANNELS];
   logic [PIX_W-1:0]       pix_cnt_in [CHANNELS];
   logic [SAMPLE_BITS-1:0] run_peak_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] run_peak_in [CHANNELS];

   logic [SAMPLE_BITS-1:0] frame_mem [CHANNELS * FRAME_PIXELS];

   // Finished frame under scan
   logic                   scan_ch_ff, scan_ch_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [SAMPLE_BITS-1:0] thr_ff, thr_in;

   // Scan read stage
   logic [CFG_W-1:0]       pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [CFG_W-1:0]       rd_pos_ff, rd_pos_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rd_last_ff, rd_last_in;

   // Level tracking and counts
   logic             prev_ff, prev_in;
   logic [CFG_W-1:0] white_ff, white_in;
   logic [CFG_W-1:0] change_ff, change_in;
   logic [NB_W-1:0]  nbound_ff, nbound_in;
   logic [CFG_W-1:0] hold_ff, hold_in;
   logic             hold_full_ff, hold_full_in;
   logic [NB_W-1:0]  bidx_ff, bidx_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ch_ff, rsp_ch_in;
   logic [CFG_W-1:0]       rsp_a_ff, rsp_a_in;
   logic                   rsp_av_ff, rsp_av_in;
   logic [CFG_W-1:0]       rsp_b_ff, rsp_b_in;
   logic                   rsp_bv_ff, rsp_bv_in;
   logic [CFG_W-1:0]       rsp_white_ff, rsp_white_in;
   logic [CFG_W-1:0]       rsp_change_ff, rsp_change_in;
   logic [NB_W-1:0]        rsp_nb_ff, rsp_nb_in;
   logic [SAMPLE_BITS-1:0] rsp_peak_ff, rsp_peak_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ch_ok;
   logic                   load_en;
   logic [PIX_W-1:0]       cur_cnt;
   logic [SAMPLE_BITS-1:0] cur_peak;
   logic [SAMPLE_BITS-1:0] new_peak;
   logic [SAMPLE_BITS-1:0] peak_qtr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [CFG_W-1:0]       hi_lim;
   logic                   lvl;
   logic                   chg;
   logic                   bnd;
   logic                   emit;

   // Decode the offered sample
   assign ch_ok    = (int'(req_channel) < CHANNELS);
   assign load_en  = cmd.load & ch_ok;
   assign cur_cnt  = pix_cnt_ff[req_channel];
   assign cur_peak = run_peak_ff[req_channel];
   assign new_peak = (req_sample > cur_peak) ? req_sample : cur_peak;
   assign peak_qtr = new_peak >> 2;
   assign wr_addr  = ADDR_W'(int'(req_channel) * FRAME_PIXELS + int'(cur_cnt));
   assign rd_addr  = ADDR_W'(int'(scan_ch_ff) * FRAME_PIXELS + int'(pos_ff[PIX_W-1:0]));

   // Clip the scan range to the frame
   assign hi_lim = (scan_last_ff > LAST_PIX) ? LAST_PIX : scan_last_ff;

   assign status.frame_end = ch_ok && (cur_cnt == PIX_W'(FRAME_PIXELS - 1));
   assign status.empty     = (scan_first_ff > hi_lim);
   assign status.pos_at_hi = (pos_ff == hi_lim);
   assign status.rd_last   = rd_vld_ff & rd_last_ff;

   // Binarise the pixel in the read stage and spot window boundaries
   assign lvl = (rd_data_ff > thr_ff);
   assign chg = (lvl != prev_ff);
   assign bnd = rd_vld_ff && chg && (rd_pos_ff >= window_low_ff)
                && (rd_pos_ff <= window_high_ff);

   // Configuration writes
   always_comb begin
      scan_first_in  = scan_first_ff;
      scan_last_in   = scan_last_ff;
      window_low_in  = window_low_ff;
      window_high_in = window_high_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_SCAN_FIRST:  scan_first_in  = csr_data;
            CSR_SCAN_LAST:   scan_last_in   = csr_data;
            CSR_WINDOW_LOW:  window_low_in  = csr_data;
            CSR_WINDOW_HIGH: window_high_in = csr_data;
            default: ;
         endcase
      end
   end

   // Advance the channel counter and peak; latch a finished frame
   always_comb begin
      pix_cnt_in  = pix_cnt_ff;
      run_peak_in = run_peak_ff;
      scan_ch_in  = scan_ch_ff;
      peak_in     = peak_ff;
      thr_in      = thr_ff;
      if (load_en) begin
         if (status.frame_end) begin
            pix_cnt_in[req_channel]  = '0;
            run_peak_in[req_channel] = '0;
            scan_ch_in               = req_channel;
            peak_in                  = new_peak;
            thr_in                   = peak_qtr + (peak_qtr << 1);
         end else begin
            pix_cnt_in[req_channel]  = cur_cnt + 1'b1;
            run_peak_in[req_channel] = new_peak;
         end
      end
   end

   // Step the scan address
   always_comb begin
      pos_in     = pos_ff;
      rd_vld_in  = cmd.issue;
      rd_last_in = cmd.issue & status.pos_at_hi;
      rd_pos_in  = pos_ff;
      if (cmd.init) begin
         pos_in = scan_first_ff;
      end else if (cmd.issue) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // Count on the first pass, pair boundaries into items on the second
   always_comb begin
      prev_in       = prev_ff;
      white_in      = white_ff;
      change_in     = change_ff;
      nbound_in     = nbound_ff;
      hold_in       = hold_ff;
      hold_full_in  = hold_full_ff;
      bidx_in       = bidx_ff;
      emit          = 1'b0;
      rsp_a_in      = rsp_a_ff;
      rsp_av_in     = rsp_av_ff;
      rsp_b_in      = rsp_b_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.clear) begin
         white_in  = '0;
         change_in = '0;
         nbound_in = '0;
      end

      if (cmd.init) begin
         prev_in      = 1'b0;
         hold_full_in = 1'b0;
         bidx_in      = '0;
      end else if (rd_vld_ff) begin
         prev_in = lvl;
         if (!cmd.pass2) begin
            white_in  = white_ff + CFG_W'(lvl);
            change_in = change_ff + CFG_W'(chg);
            nbound_in = nbound_ff + NB_W'(bnd);
         end else if (bnd) begin
            bidx_in = bidx_ff + 1'b1;
            if (!hold_full_ff) begin
               hold_in      = rd_pos_ff;
               hold_full_in = 1'b1;
            end else begin
               hold_full_in = 1'b0;
               emit         = 1'b1;
               rsp_a_in     = hold_ff;
               rsp_av_in    = 1'b1;
               rsp_b_in     = rd_pos_ff;
               rsp_bv_in    = 1'b1;
               rsp_last_in  = ((bidx_ff + 1'b1) == nbound_ff);
            end
         end
      end

      // Send the odd boundary, or the single empty item
      if (cmd.flush) begin
         if (hold_full_ff) begin
            hold_full_in = 1'b0;
            emit         = 1'b1;
            rsp_a_in     = hold_ff;
            rsp_av_in    = 1'b1;
            rsp_b_in     = '0;
            rsp_bv_in    = 1'b0;
            rsp_last_in  = 1'b1;
         end else if (nbound_ff == '0) begin
            emit        = 1'b1;
            rsp_a_in    = '0;
            rsp_av_in   = 1'b0;
            rsp_b_in    = '0;
            rsp_bv_in   = 1'b0;
            rsp_last_in = 1'b1;
         end
      end
   end

   // Frame-wide fields ride on every item
   always_comb begin
      rsp_valid_in  = emit;
      rsp_ch_in     = rsp_ch_ff;
      rsp_white_in  = rsp_white_ff;
      rsp_change_in = rsp_change_ff;
      rsp_nb_in     = rsp_nb_ff;
      rsp_peak_in   = rsp_peak_ff;
      if (emit) begin
         rsp_ch_in     = scan_ch_ff;
         rsp_white_in  = white_ff;
         rsp_change_in = change_ff;
         rsp_nb_in     = nbound_ff;
         rsp_peak_in   = peak_ff;
      end
   end

   // Frame store: one write port for loading, one registered read port for scanning
   always_ff @(posedge clock) begin
      if (load_en) begin
         frame_mem[wr_addr] <= req_sample;
      end
      if (cmd.issue) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_first_ff  <= SCAN_FIRST_RST;
         scan_last_ff   <= SCAN_LAST_RST;
         window_low_ff  <= WINDOW_LOW_RST;
         window_high_ff <= WINDOW_HIGH_RST;
         for (int c = 0; c < CHANNELS; c++) begin
            pix_cnt_ff[c]  <= '0;
            run_peak_ff[c] <= '0;
         end
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         hold_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_first_ff  <= scan_first_in;
         scan_last_ff   <= scan_last_in;
         window_low_ff  <= window_low_in;
         window_high_ff <= window_high_in;
         pix_cnt_ff     <= pix_cnt_in;
         run_peak_ff    <= run_peak_in;
         rd_vld_ff      <= rd_vld_in;
         rd_last_ff     <= rd_last_in;
         hold_full_ff   <= hold_full_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      scan_ch_ff    <= scan_ch_in;
      peak_ff       <= peak_in;
      thr_ff        <= thr_in;
      pos_ff        <= pos_in;
      rd_pos_ff     <= rd_pos_in;
      prev_ff       <= prev_in;
      white_ff      <= white_in;
      change_ff     <= change_in;
      nbound_ff     <= nbound_in;
      hold_ff       <= hold_in;
      bidx_ff       <= bidx_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_a_ff      <= rsp_a_in;
      rsp_av_ff     <= rsp_av_in;
      rsp_b_ff      <= rsp_b_in;
      rsp_bv_ff     <= rsp_bv_in;
      rsp_white_ff  <= rsp_white_in;
      rsp_change_ff <= rsp_change_in;
      rsp_nb_ff     <= rsp_nb_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_channel      = rsp_ch_ff;
   assign rsp_boundary_a       = rsp_a_ff;
   assign rsp_boundary_a_valid = rsp_av_ff;
   assign rsp_boundary_b       = rsp_b_ff;
   assign rsp_boundary_b_valid = rsp_bv_ff;
   assign rsp_white_count      = rsp_white_ff;
   assign rsp_change_count     = rsp_change_ff;
   assign rsp_boundary_count   = rsp_nb_ff;
   assign rsp_peak             = rsp_peak_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

`default_nettype wire

// ----- src/lsee_checker.sv -----
// Port-level checks on result items and busy, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lsee_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [lsee_pkg::CFG_W-1:0]     rsp_boundary_a,
   input logic                           rsp_boundary_a_valid,
   input logic [lsee_pkg::CFG_W-1:0]     rsp_boundary_b,
   input logic                           rsp_boundary_b_valid,
   input logic                           rsp_last
);

   // An item without a first boundary is the lone empty item of its frame
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_boundary_a_valid |->
         rsp_boundary_a == '0 && !rsp_boundary_b_valid && rsp_last)
      else $error("item without first boundary is not an empty final item");

   // A missing second boundary only closes a frame, with a zero index
   a_odd_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_boundary_b_valid |-> rsp_boundary_b == '0 && rsp_last)
      else $error("item without second boundary is not final");

   // Boundaries in one item come in pixel order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_boundary_b_valid |-> rsp_boundary_b > rsp_boundary_a)
      else $error("boundary pair out of order");

   // Nothing follows the final item of a frame straight away
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("item right after final item");

   // Busy rises only after a start
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without start");

endmodule

bind line_scan_edge_extractor lsee_checker u_lsee_checker (.*);

`default_nettype wire
